>>> sv/rmq_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the rotation matrix to quaternion converter.
// No dependencies.
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int RAD_W     = 17;
   localparam int NUM_W     = 17;
   localparam int ROOT_W    = 16;
   localparam int SQ_BITS   = 2;
   localparam int SQ_LAT    = ROOT_W / SQ_BITS;
   localparam int QBITS     = 15;
   localparam int DIV_BITS  = 3;
   localparam int DIV_STEPS = QBITS / DIV_BITS;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int TOTAL_LAT = SQ_LAT + DIV_LAT + 2;
   localparam int SAT_LIM   = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

endpackage

>>> sv/rmq_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root of (radicand << FRAC_BITS), two root bits per stage.
// Depends on rmq_pkg.
module rmq_sqrt
   import rmq_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   logic [32:0]       rem_ff  [SQ_LAT];
   logic [ROOT_W-1:0] root_ff [SQ_LAT];

   for (genvar j = 0; j < SQ_LAT; j++) begin : g_stage
      logic [32:0]       rem_src, rem_in;
      logic [ROOT_W-1:0] root_src, root_in;
      if (j == 0) begin : g_first
         assign rem_src  = 33'({rad, {FRAC_BITS{1'b0}}});
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
      end
      always_comb begin
         logic [32:0] trial;
         int k;
         rem_in  = rem_src;
         root_in = root_src;
         for (int b = 0; b < SQ_BITS; b++) begin
            k = ROOT_W - 1 - SQ_BITS * j - b;
            trial = (33'(root_in) << (k + 1)) | (33'd1 << (2 * k));
            if (rem_in >= trial) begin
               rem_in  = rem_in - trial;
               root_in = root_in | (ROOT_W'(1) << k);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end
   end

   assign root = root_ff[SQ_LAT-1];

endmodule

>>> sv/rmq_div.sv
`timescale 1ns / 1ps
// Pipelined rounded division round(num * 2^FRAC_BITS / (2 * root)), saturated.
// Depends on rmq_pkg.
module rmq_div
   import rmq_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0]        root,
   output logic signed [OUT_W-1:0]  quot
);

   logic [31:0]         rem_ff  [DIV_STEPS+1];
   logic [QBITS-1:0]    q_ff    [DIV_STEPS+1];
   logic [ROOT_W:0]     dv_ff   [DIV_STEPS+1];
   logic                neg_ff  [DIV_STEPS+1];
   logic                ovf_ff  [DIV_STEPS+1];
   logic                zero_ff [DIV_STEPS+1];
   logic signed [OUT_W-1:0] quot_ff;

   logic [NUM_W-1:0] mag;
   logic [31:0]      dd;
   logic [ROOT_W:0]  dv;

   assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign dd  = 32'({mag, {FRAC_BITS{1'b0}}}) + 32'(root);
   assign dv  = {root, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= dd;
         q_ff[0]    <= '0;
         dv_ff[0]   <= dv;
         neg_ff[0]  <= num[NUM_W-1];
         ovf_ff[0]  <= 33'(dd) >= (33'(dv) << QBITS);
         zero_ff[0] <= (root == '0);
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      logic [31:0]      rem_in;
      logic [QBITS-1:0] q_in;
      always_comb begin
         logic [31:0] sub;
         int k;
         rem_in = rem_ff[s-1];
         q_in   = q_ff[s-1];
         for (int b = 0; b < DIV_BITS; b++) begin
            k = QBITS - 1 - DIV_BITS * (s - 1) - b;
            sub = 32'(dv_ff[s-1]) << k;
            if (rem_in >= sub) begin
               rem_in = rem_in - sub;
               q_in   = q_in | (QBITS'(1) << k);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
            dv_ff[s]   <= dv_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
         end
      end
   end

   logic [OUT_W-1:0] qmag;
   always_comb begin
      priority if (zero_ff[DIV_STEPS]) begin
         qmag = '0;
      end else if (ovf_ff[DIV_STEPS] || (OUT_W'(q_ff[DIV_STEPS]) > OUT_W'(SAT_LIM))) begin
         qmag = OUT_W'(SAT_LIM);
      end else begin
         qmag = OUT_W'(q_ff[DIV_STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= neg_ff[DIV_STEPS] ? OUT_W'(-qmag) : OUT_W'(qmag);
      end
   end

   assign quot = quot_ff;

endmodule

>>> sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Top level: 3x3 rotation matrix (Q1.14) to unit quaternion, Shepperd's method.
// Depends on rmq_pkg, rmq_sqrt, rmq_div.
//
// One transaction is accepted every clock cycle while the pipeline advances: an
// input register holds the selected case, radicand and numerators, eight
// stages of the square root resolve two root bits each, seven divider stages (an
// operand register, five stages of three quotient bits each and a saturation
// register) divide the three numerators by twice the root, and one output
// register selects the components. The whole pipeline advances together
// whenever the output register is empty or being taken, so a stalled result holds
// every stage and nothing is lost or repeated. Components saturate to +/-1.0.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [IN_W-1:0]  req_r00,
   input  logic signed [IN_W-1:0]  req_r01,
   input  logic signed [IN_W-1:0]  req_r02,
   input  logic signed [IN_W-1:0]  req_r10,
   input  logic signed [IN_W-1:0]  req_r11,
   input  logic signed [IN_W-1:0]  req_r12,
   input  logic signed [IN_W-1:0]  req_r20,
   input  logic signed [IN_W-1:0]  req_r21,
   input  logic signed [IN_W-1:0]  req_r22,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_quat_x,
   output logic signed [OUT_W-1:0] rsp_quat_y,
   output logic signed [OUT_W-1:0] rsp_quat_z,
   output logic signed [OUT_W-1:0] rsp_quat_w,
   output logic [1:0]              rsp_case_used
);

   localparam int SEL_LAT = SQ_LAT + DIV_LAT;

   logic en;
   logic valid_ff [TOTAL_LAT];

   assign en        = !valid_ff[TOTAL_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL_LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // case select and radicand
   logic signed [18:0] t, rad_s;
   case_type           sel_in;
   logic signed [NUM_W-1:0] na_in, nb_in, nc_in;
   logic signed [NUM_W-1:0] d_xy, d_yz, d_xz, s_01, s_02, s_12;

   assign t    = 19'(req_r00) + 19'(req_r11) + 19'(req_r22) + 19'(1 << FRAC_BITS);
   assign d_xy = NUM_W'(req_r21) - NUM_W'(req_r12);
   assign d_yz = NUM_W'(req_r02) - NUM_W'(req_r20);
   assign d_xz = NUM_W'(req_r10) - NUM_W'(req_r01);
   assign s_01 = NUM_W'(req_r01) + NUM_W'(req_r10);
   assign s_02 = NUM_W'(req_r02) + NUM_W'(req_r20);
   assign s_12 = NUM_W'(req_r12) + NUM_W'(req_r21);

   always_comb begin
      priority if (t > 0) begin
         sel_in = CASE_TRACE;
         rad_s  = t;
         na_in  = d_xy;
         nb_in  = d_yz;
         nc_in  = d_xz;
      end else if (req_r00 > req_r11 && req_r00 > req_r22) begin
         sel_in = CASE_X;
         rad_s  = 19'(1 << FRAC_BITS) + 19'(req_r00) - 19'(req_r11) - 19'(req_r22);
         na_in  = s_01;
         nb_in  = s_02;
         nc_in  = d_xy;
      end else if (req_r11 > req_r22) begin
         sel_in = CASE_Y;
         rad_s  = 19'(1 << FRAC_BITS) + 19'(req_r11) - 19'(req_r00) - 19'(req_r22);
         na_in  = s_01;
         nb_in  = s_12;
         nc_in  = d_yz;
      end else begin
         sel_in = CASE_Z;
         rad_s  = 19'(1 << FRAC_BITS) + 19'(req_r22) - 19'(req_r00) - 19'(req_r11);
         na_in  = s_02;
         nb_in  = s_12;
         nc_in  = d_xz;
      end
   end

   logic [RAD_W-1:0]        rad_ff;
   logic signed [NUM_W-1:0] na_ff [SQ_LAT+1];
   logic signed [NUM_W-1:0] nb_ff [SQ_LAT+1];
   logic signed [NUM_W-1:0] nc_ff [SQ_LAT+1];
   case_type                sel_ff [SEL_LAT+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff    <= rad_s[18] ? '0 : rad_s[RAD_W-1:0];
         na_ff[0]  <= na_in;
         nb_ff[0]  <= nb_in;
         nc_ff[0]  <= nc_in;
         sel_ff[0] <= sel_in;
         for (int i = 1; i <= SQ_LAT; i++) begin
            na_ff[i] <= na_ff[i-1];
            nb_ff[i] <= nb_ff[i-1];
            nc_ff[i] <= nc_ff[i-1];
         end
         for (int i = 1; i <= SEL_LAT; i++) sel_ff[i] <= sel_ff[i-1];
      end
   end

   logic [ROOT_W-1:0] root;

   rmq_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   // root is aligned with numerator delay index SQ_LAT
   logic [ROOT_W:0]         half_w;
   logic signed [OUT_W-1:0] half_in;
   logic signed [OUT_W-1:0] half_ff [DIV_LAT];

   assign half_w  = ({1'b0, root} + 17'd1) >> 1;
   assign half_in = (half_w > 17'(SAT_LIM)) ? OUT_W'(SAT_LIM) : OUT_W'(half_w);

   always_ff @(posedge clock) begin
      if (en) begin
         half_ff[0] <= half_in;
         for (int i = 1; i < DIV_LAT; i++) half_ff[i] <= half_ff[i-1];
      end
   end

   logic signed [OUT_W-1:0] qa, qb, qc;

   rmq_div u_div_a (.clock(clock), .en(en), .num(na_ff[SQ_LAT]), .root(root), .quot(qa));
   rmq_div u_div_b (.clock(clock), .en(en), .num(nb_ff[SQ_LAT]), .root(root), .quot(qb));
   rmq_div u_div_c (.clock(clock), .en(en), .num(nc_ff[SQ_LAT]), .root(root), .quot(qc));

   logic signed [OUT_W-1:0] x_in, y_in, z_in, w_in;
   logic signed [OUT_W-1:0] x_ff, y_ff, z_ff, w_ff;
   case_type                case_ff;
   logic signed [OUT_W-1:0] hv;
   case_type                sv_sel;

   assign hv     = half_ff[DIV_LAT-1];
   assign sv_sel = sel_ff[SEL_LAT];

   always_comb begin
      unique case (sv_sel)
         CASE_TRACE: begin x_in = qa; y_in = qb; z_in = qc; w_in = hv; end
         CASE_X:     begin x_in = hv; y_in = qa; z_in = qb; w_in = qc; end
         CASE_Y:     begin x_in = qa; y_in = hv; z_in = qb; w_in = qc; end
         CASE_Z:     begin x_in = qa; y_in = qb; z_in = hv; w_in = qc; end
         default:    begin x_in = qa; y_in = qb; z_in = qc; w_in = hv; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         w_ff    <= w_in;
         case_ff <= sv_sel;
      end
   end

   assign rsp_quat_x    = x_ff;
   assign rsp_quat_y    = y_ff;
   assign rsp_quat_z    = z_ff;
   assign rsp_quat_w    = w_ff;
   assign rsp_case_used = case_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   a_trace_w_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_used == CASE_TRACE |-> !rsp_quat_w[OUT_W-1])
      else $error("negative w in trace case");

   a_root_comp_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_case_used == CASE_X && rsp_quat_x[OUT_W-1]) &&
                    !(rsp_case_used == CASE_Y && rsp_quat_y[OUT_W-1]) &&
                    !(rsp_case_used == CASE_Z && rsp_quat_z[OUT_W-1]))
      else $error("negative root component");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_x <= OUT_W'(SAT_LIM) && rsp_quat_x >= -OUT_W'(SAT_LIM) &&
                    rsp_quat_y <= OUT_W'(SAT_LIM) && rsp_quat_y >= -OUT_W'(SAT_LIM) &&
                    rsp_quat_z <= OUT_W'(SAT_LIM) && rsp_quat_z >= -OUT_W'(SAT_LIM) &&
                    rsp_quat_w <= OUT_W'(SAT_LIM) && rsp_quat_w >= -OUT_W'(SAT_LIM))
      else $error("component beyond saturation limit");

endmodule
